@@ design/csls_pkg.sv @@
// ----------------------------------------------------------------------------
// csls_pkg: shared constants and types of the coordinate seeded sampler
// Field widths, LCG constants, opcodes and register indexes used by the
// channel interfaces and by the sampler core.
// ----------------------------------------------------------------------------
package csls_pkg;

    localparam int OP_W      = 3;
    localparam int COORD_W   = 32;
    localparam int SEED_W    = 64;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [SEED_W-1:0] t_seed;
    typedef logic [OP_W-1:0]   t_opcode;

    localparam t_seed LCG_MUL = 64'd6364136223846793005;
    localparam t_seed LCG_ADD = 64'd1442695040888963407;

    localparam int DRAW_SHIFT = 24;
    localparam int DIV_STEPS  = SEED_W - DRAW_SHIFT;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam t_opcode OP_SEED_COORD = 3'd0;
    localparam t_opcode OP_SEED_GIVEN = 3'd1;
    localparam t_opcode OP_DRAW       = 3'd2;
    localparam t_opcode OP_CHOOSE2    = 3'd3;
    localparam t_opcode OP_CHOOSE4    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SALT        = 2'd1;

endpackage

@@ design/csls_in_if.sv @@
// ----------------------------------------------------------------------------
// csls_in_if: command channel of the sampler
// Valid/ready channel carrying one opcode with its operands.
// ----------------------------------------------------------------------------
interface csls_in_if;
    logic                              valid;
    logic                              ready;
    logic [csls_pkg::OP_W-1:0]         opcode;
    logic signed [csls_pkg::COORD_W-1:0] coord_x;
    logic signed [csls_pkg::COORD_W-1:0] coord_z;
    logic [csls_pkg::SEED_W-1:0]       seed_value;
    logic [csls_pkg::FIELD_W-1:0]      draw_range;
    logic [csls_pkg::FIELD_W-1:0]      choice_a;
    logic [csls_pkg::FIELD_W-1:0]      choice_b;
    logic [csls_pkg::FIELD_W-1:0]      choice_c;
    logic [csls_pkg::FIELD_W-1:0]      choice_d;

    modport source (
        output valid, opcode, coord_x, coord_z, seed_value, draw_range,
               choice_a, choice_b, choice_c, choice_d,
        input  ready
    );
    modport sink (
        input  valid, opcode, coord_x, coord_z, seed_value, draw_range,
               choice_a, choice_b, choice_c, choice_d,
        output ready
    );
endinterface

@@ design/csls_out_if.sv @@
// ----------------------------------------------------------------------------
// csls_out_if: result channel of the sampler
// Valid/ready channel carrying one drawn value and its error flag.
// ----------------------------------------------------------------------------
interface csls_out_if;
    logic                         valid;
    logic                         ready;
    logic [csls_pkg::FIELD_W-1:0] drawn_value;
    logic                         range_error;

    modport source (output valid, drawn_value, range_error, input ready);
    modport sink (input valid, drawn_value, range_error, output ready);
endinterface

@@ design/csls_cfg_if.sv @@
// ----------------------------------------------------------------------------
// csls_cfg_if: register write channel of the sampler
// Valid/ready channel carrying a register index and 64-bit write data.
// ----------------------------------------------------------------------------
interface csls_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [csls_pkg::CFG_IDX_W-1:0] index;
    logic [csls_pkg::SEED_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/coordinate_seeded_lcg_sampler.sv @@
// ----------------------------------------------------------------------------
// coordinate_seeded_lcg_sampler: LCG seeded random sampler
// Derives a layer seed from the global seed and salt, seeds a running seed
// from a coordinate pair or a given value, and draws bounded samples.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on i_in, results leave on o_out, registers are written on
// i_cfg (index 0 global seed, index 1 salt, other indexes ignored).
// Every mixing step runs on one shared 32x32 multiplier. A register write
// re-derives the layer seed; reset starts the same derivation from zero
// registers, and i_in is not ready meanwhile. Seeding from coordinates
// gives no result; a given seed is loaded into the running seed in the
// cycle after it is accepted. A draw runs the bit-serial remainder of the
// shifted seed, then the seed advance, then fills the output register. A
// choose skips the remainder, since its candidate index is taken straight
// from the low bits of the shifted seed. The output register holds a
// finished result while the receiver stalls; the next command is still
// accepted, and its result waits until the register is free. A register
// write has priority over a command offered in the same cycle.
// ----------------------------------------------------------------------------
module coordinate_seeded_lcg_sampler #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    csls_in_if.sink           i_in,
    csls_out_if.source        o_out,
    csls_cfg_if.sink          i_cfg
);

    localparam int RW = (SAMPLE_BITS < csls_pkg::FIELD_W) ? SAMPLE_BITS : csls_pkg::FIELD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] JOB_DERIVE = 2'd0;
    localparam logic [1:0] JOB_COORD  = 2'd1;
    localparam logic [1:0] JOB_DRAW   = 2'd2;

    localparam logic [2:0] PH_LAST    = 3'd5;
    localparam logic [2:0] K_DERIVE   = 3'd5;
    localparam logic [2:0] K_COORD    = 3'd3;

    logic [1:0]               r_state;
    logic [1:0]               r_job;
    logic [2:0]               r_phase;
    logic [2:0]               r_kcnt;
    logic [csls_pkg::DCNT_W-1:0] r_dcnt;

    csls_pkg::t_seed          r_gseed;
    csls_pkg::t_seed          r_salt;
    csls_pkg::t_seed          r_layer;
    csls_pkg::t_seed          r_seed;
    csls_pkg::t_seed          r_ms;
    csls_pkg::t_seed          r_mf;
    csls_pkg::t_seed          r_t;
    csls_pkg::t_seed          r_acc;

    logic [csls_pkg::COORD_W-1:0] r_x;
    logic [csls_pkg::COORD_W-1:0] r_z;
    csls_pkg::t_opcode        r_op;
    logic [RW-1:0]            r_range;
    logic [RW-1:0]            r_ca;
    logic [RW-1:0]            r_cb;
    logic [RW-1:0]            r_cc;
    logic [RW-1:0]            r_cd;
    logic [csls_pkg::DIV_STEPS-1:0] r_dq;
    logic [RW-1:0]            r_rem;

    logic                     r_out_valid;
    logic [csls_pkg::FIELD_W-1:0] r_out_val;
    logic                     r_out_err;

    logic [31:0]              w_ma;
    logic [31:0]              w_mb;
    csls_pkg::t_seed          w_prod;
    csls_pkg::t_seed          w_acc_sh;
    csls_pkg::t_seed          w_x_ext;
    csls_pkg::t_seed          w_z_ext;
    logic [RW:0]              w_trial;
    logic [RW+1:0]            w_diff;
    logic                     w_in_xfer;
    logic                     w_cfg_xfer;
    logic                     w_load_out;
    logic [csls_pkg::FIELD_W-1:0] n_out_val;
    logic                     n_out_err;

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign i_in.ready  = (r_state == ST_IDLE) && !i_cfg.valid;
    assign w_cfg_xfer  = i_cfg.valid && i_cfg.ready;
    assign w_in_xfer   = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.drawn_value = r_out_val;
    assign o_out.range_error = r_out_err;

    assign w_x_ext = {{32{r_x[31]}}, r_x};
    assign w_z_ext = {{32{r_z[31]}}, r_z};

    // Low 64 bits of a 64x64 product from three partial products.
    always_comb begin
        case (r_phase)
            3'd0: begin
                w_ma = r_ms[31:0];
                w_mb = csls_pkg::LCG_MUL[31:0];
            end
            3'd1: begin
                w_ma = r_ms[31:0];
                w_mb = csls_pkg::LCG_MUL[63:32];
            end
            3'd2: begin
                w_ma = r_ms[63:32];
                w_mb = csls_pkg::LCG_MUL[31:0];
            end
            3'd3: begin
                w_ma = r_ms[31:0];
                w_mb = r_t[31:0];
            end
            3'd4: begin
                w_ma = r_ms[31:0];
                w_mb = r_t[63:32];
            end
            3'd5: begin
                w_ma = r_ms[63:32];
                w_mb = r_t[31:0];
            end
            default: begin
                w_ma = r_ms[31:0];
                w_mb = r_t[31:0];
            end
        endcase
    end

    assign w_prod   = 64'(w_ma) * 64'(w_mb);
    assign w_acc_sh = r_acc + {w_prod[31:0], 32'h0};

    assign w_trial = {r_rem, r_dq[csls_pkg::DIV_STEPS-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_range};

    always_comb begin
        n_out_err = 1'b0;
        case (r_op)
            csls_pkg::OP_DRAW: begin
                n_out_err = (r_range == '0);
                n_out_val = n_out_err ? '0 : csls_pkg::FIELD_W'(r_rem);
            end
            csls_pkg::OP_CHOOSE2: begin
                n_out_val = csls_pkg::FIELD_W'(r_dq[0] ? r_cb : r_ca);
            end
            csls_pkg::OP_CHOOSE4: begin
                case (r_dq[1:0])
                    2'd0:    n_out_val = csls_pkg::FIELD_W'(r_ca);
                    2'd1:    n_out_val = csls_pkg::FIELD_W'(r_cb);
                    2'd2:    n_out_val = csls_pkg::FIELD_W'(r_cc);
                    default: n_out_val = csls_pkg::FIELD_W'(r_cd);
                endcase
            end
            default: begin
                n_out_val = '0;
            end
        endcase
    end

    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_MIX;
            r_job       <= JOB_DERIVE;
            r_phase     <= '0;
            r_kcnt      <= '0;
            r_dcnt      <= '0;
            r_gseed     <= '0;
            r_salt      <= '0;
            r_ms        <= '0;
            r_mf        <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_cfg_xfer) begin
                        if (i_cfg.index == csls_pkg::REG_GLOBAL_SEED) begin
                            r_gseed <= i_cfg.data;
                            r_ms    <= r_salt;
                            r_mf    <= r_salt;
                            r_job   <= JOB_DERIVE;
                            r_kcnt  <= '0;
                            r_phase <= '0;
                            r_state <= ST_MIX;
                        end else if (i_cfg.index == csls_pkg::REG_SALT) begin
                            r_salt  <= i_cfg.data;
                            r_ms    <= i_cfg.data;
                            r_mf    <= i_cfg.data;
                            r_job   <= JOB_DERIVE;
                            r_kcnt  <= '0;
                            r_phase <= '0;
                            r_state <= ST_MIX;
                        end
                    end else if (w_in_xfer) begin
                        r_op    <= i_in.opcode;
                        r_x     <= i_in.coord_x;
                        r_z     <= i_in.coord_z;
                        r_ca    <= i_in.choice_a[RW-1:0];
                        r_cb    <= i_in.choice_b[RW-1:0];
                        r_cc    <= i_in.choice_c[RW-1:0];
                        r_cd    <= i_in.choice_d[RW-1:0];
                        r_dq    <= r_seed[csls_pkg::SEED_W-1:csls_pkg::DRAW_SHIFT];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_kcnt  <= '0;
                        r_phase <= '0;
                        case (i_in.opcode)
                            csls_pkg::OP_SEED_COORD: begin
                                r_ms    <= r_layer;
                                r_mf    <= {{32{i_in.coord_x[31]}}, i_in.coord_x};
                                r_job   <= JOB_COORD;
                                r_state <= ST_MIX;
                            end
                            csls_pkg::OP_SEED_GIVEN: begin
                                r_seed <= i_in.seed_value;
                            end
                            csls_pkg::OP_DRAW: begin
                                r_range <= i_in.draw_range[RW-1:0];
                                r_ms    <= r_seed;
                                r_mf    <= r_layer;
                                r_job   <= JOB_DRAW;
                                r_state <= ST_DIV;
                            end
                            csls_pkg::OP_CHOOSE2, csls_pkg::OP_CHOOSE4: begin
                                r_ms    <= r_seed;
                                r_mf    <= r_layer;
                                r_job   <= JOB_DRAW;
                                r_state <= ST_MIX;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_dq <= {r_dq[csls_pkg::DIV_STEPS-2:0], 1'b0};
                    if (!w_diff[RW+1]) begin
                        r_rem <= w_diff[RW-1:0];
                    end else begin
                        r_rem <= w_trial[RW-1:0];
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == csls_pkg::DCNT_W'(csls_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    case (r_phase)
                        3'd0: begin
                            r_acc   <= w_prod + csls_pkg::LCG_ADD;
                            r_phase <= r_phase + 1'b1;
                        end
                        3'd1: begin
                            r_acc   <= w_acc_sh;
                            r_phase <= r_phase + 1'b1;
                        end
                        3'd2: begin
                            r_t     <= w_acc_sh;
                            r_phase <= r_phase + 1'b1;
                        end
                        3'd3: begin
                            r_acc   <= w_prod + r_mf;
                            r_phase <= r_phase + 1'b1;
                        end
                        3'd4: begin
                            r_acc   <= w_acc_sh;
                            r_phase <= r_phase + 1'b1;
                        end
                        default: begin
                            r_phase <= '0;
                            r_kcnt  <= r_kcnt + 1'b1;
                            case (r_job)
                                JOB_DERIVE: begin
                                    if (r_kcnt == K_DERIVE) begin
                                        r_layer <= w_acc_sh;
                                        r_state <= ST_IDLE;
                                    end else if (r_kcnt == 3'd2) begin
                                        r_ms <= r_gseed;
                                        r_mf <= w_acc_sh;
                                    end else begin
                                        r_ms <= w_acc_sh;
                                        if (r_kcnt < 3'd2) begin
                                            r_mf <= w_acc_sh;
                                        end
                                    end
                                end
                                JOB_COORD: begin
                                    if (r_kcnt == K_COORD) begin
                                        r_seed  <= w_acc_sh;
                                        r_state <= ST_IDLE;
                                    end else begin
                                        r_ms <= w_acc_sh;
                                        r_mf <= r_kcnt[0] ? w_x_ext : w_z_ext;
                                    end
                                end
                                default: begin
                                    r_seed  <= w_acc_sh;
                                    r_state <= ST_OUT;
                                end
                            endcase
                        end
                    endcase
                end
                default: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_val <= n_out_val;
            r_out_err <= n_out_err;
        end
    end

`ifndef ASSERT_OFF
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX) |-> (r_phase <= PH_LAST))
        else $error("mix phase counter out of range");

    a_draw_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX && r_job == JOB_DRAW && r_phase == PH_LAST)
        |=> (r_state == ST_OUT))
        else $error("draw did not reach output stage after seed advance");

    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.opcode == csls_pkg::OP_SEED_GIVEN)
        |=> (r_seed == $past(i_in.seed_value)))
        else $error("given seed not loaded");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_error) |-> (o_out.drawn_value == '0))
        else $error("range error result carries a nonzero value");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dcnt < csls_pkg::DCNT_W'(csls_pkg::DIV_STEPS)))
        else $error("remainder step counter overran");
`endif

endmodule
